@@ rtl/niao_pkg.sv @@
package niao_pkg;

    localparam int NPOS       = 4;
    localparam int MAX_RANK   = 4;
    localparam int DIM_LIMIT  = 1024;
    localparam int RANK_LIM   = (MAX_RANK < NPOS) ? MAX_RANK : NPOS;

    localparam int IDX_W      = 10;
    localparam int EXT_W      = 11;
    localparam int CNT_W      = 3;
    localparam int OFF_W      = 40;
    localparam int PAIR_W     = 2 * EXT_W;
    localparam int SCALE_W    = 3 * EXT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CNT_W-1:0] RANK_LIMIT  = CNT_W'(RANK_LIM);
    localparam logic [31:0]      DIM_LIMIT_U = 32'(DIM_LIMIT);

    localparam logic KIND_OFFSET  = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_3 = 3'd4;

    typedef struct packed {
        logic kind;
        logic err;
    } t_ctrl;

    typedef struct packed {
        logic [OFF_W-1:0] term;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] inc;
        logic             inc_ok;
        logic             used;
    } t_lane;

    // Extents above the limit behave as the limit itself.
    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] d);
        logic [31:0] wide;
        wide = 32'(d);
        return (wide > DIM_LIMIT_U) ? EXT_W'(DIM_LIMIT_U) : d;
    endfunction

endpackage

@@ rtl/niao_in_if.sv @@
interface niao_in_if;
    import niao_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [CNT_W-1:0] index_count;
    logic [IDX_W-1:0] idx_0;
    logic [IDX_W-1:0] idx_1;
    logic [IDX_W-1:0] idx_2;
    logic [IDX_W-1:0] idx_3;

    modport source (
        output valid, kind, index_count, idx_0, idx_1, idx_2, idx_3,
        input  ready
    );
    modport sink (
        input  valid, kind, index_count, idx_0, idx_1, idx_2, idx_3,
        output ready
    );
endinterface

@@ rtl/niao_out_if.sv @@
interface niao_out_if;
    import niao_pkg::*;

    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] linear_offset;
    logic [IDX_W-1:0] next_0;
    logic [IDX_W-1:0] next_1;
    logic [IDX_W-1:0] next_2;
    logic [IDX_W-1:0] next_3;
    logic             count_error;
    logic             wrapped;

    modport source (
        output valid, linear_offset, next_0, next_1, next_2, next_3,
               count_error, wrapped,
        input  ready
    );
    modport sink (
        input  valid, linear_offset, next_0, next_1, next_2, next_3,
               count_error, wrapped,
        output ready
    );
endinterface

@@ rtl/niao_lane.sv @@
module niao_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_used,
    input  logic [niao_pkg::IDX_W-1:0]   i_idx,
    input  logic [niao_pkg::EXT_W-1:0]   i_ext,
    input  logic [niao_pkg::SCALE_W-1:0] i_scale,
    output niao_pkg::t_lane              o_res
);
    import niao_pkg::*;

    localparam int PROD_W = IDX_W + SCALE_W;

    logic [PROD_W-1:0] w_prod;
    logic [EXT_W-1:0]  w_inc;
    t_lane             n_res;
    t_lane             r_res;

    always_comb begin
        w_prod = PROD_W'(i_idx) * PROD_W'(i_scale);
        w_inc  = EXT_W'(i_idx) + EXT_W'(1);

        n_res.term   = i_used ? w_prod[OFF_W-1:0] : '0;
        n_res.idx    = i_idx;
        n_res.inc    = w_inc[IDX_W-1:0];
        // A position steps up only while it stays below its extent.
        n_res.inc_ok = (w_inc < i_ext);
        n_res.used   = i_used;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

@@ rtl/niao_merge.sv @@
module niao_merge (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  niao_pkg::t_ctrl            i_ctrl,
    input  niao_pkg::t_lane            i_lane [niao_pkg::NPOS],
    output logic [niao_pkg::OFF_W-1:0] o_offset,
    output logic [niao_pkg::IDX_W-1:0] o_next [niao_pkg::NPOS],
    output logic                       o_err,
    output logic                       o_wrap
);
    import niao_pkg::*;

    logic [OFF_W-1:0] n_offset;
    logic [IDX_W-1:0] n_next [NPOS];
    logic             n_wrap;
    logic [OFF_W-1:0] r_offset;
    logic [IDX_W-1:0] r_next [NPOS];
    logic             r_err;
    logic             r_wrap;

    always_comb begin
        logic [OFF_W-1:0] sum;
        logic             carry;
        logic [IDX_W-1:0] adv [NPOS];

        sum   = '0;
        carry = 1'b1;
        for (int k = 0; k < NPOS; k++) begin
            sum    = sum + i_lane[k].term;
            adv[k] = i_lane[k].idx;
        end
        // Odometer carry ripples from the innermost used position outward.
        for (int k = NPOS - 1; k >= 0; k--) begin
            if (i_lane[k].used && carry) begin
                adv[k] = i_lane[k].inc_ok ? i_lane[k].inc : '0;
                carry  = ~i_lane[k].inc_ok;
            end
        end

        n_offset = '0;
        n_wrap   = 1'b0;
        for (int k = 0; k < NPOS; k++) begin
            n_next[k] = i_lane[k].idx;
        end
        if (!i_ctrl.err) begin
            if (i_ctrl.kind == KIND_OFFSET) begin
                n_offset = sum;
            end else begin
                n_wrap = carry;
                for (int k = 0; k < NPOS; k++) begin
                    n_next[k] = adv[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_offset <= n_offset;
            r_next   <= n_next;
            r_err    <= i_ctrl.err;
            r_wrap   <= n_wrap;
        end
    end

    assign o_offset = r_offset;
    assign o_next   = r_next;
    assign o_err    = r_err;
    assign o_wrap   = r_wrap;
endmodule

@@ rtl/nd_index_offset_and_advance_unit.sv @@
// Row-major address generator for tensors of up to four dimensions.
// The shape sits in five registers written through the plain write port:
// index 0 is the rank, indices 1 to 4 the extents, outermost first.
// Write them only while no word is in flight.
// Each word on i_item is either an offset request or an advance request
// and produces exactly one word on o_result, in order.
// From acceptance to o_result.valid a word passes through input and
// shape capture, scale products, one lane per position (multiply and
// increment test), then the merge that sums the terms and ripples carries.
// Throughput is one word per cycle while the receiver is ready; each stage
// moves on whenever the stage after it is empty or moving; bubbles close up.
// When the receiver stalls, the result is held in the output register and
// the stages behind it keep filling until all four hold a word; only then
// does i_item.ready drop.
// Reset empties the pipeline and returns the shape to rank 0 with every
// extent 1.
module nd_index_offset_and_advance_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [niao_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [niao_pkg::CFG_DATA_W-1:0] i_cfg_data,
    niao_in_if.sink                         i_item,
    niao_out_if.source                      o_result
);
    import niao_pkg::*;

    // Shape registers.
    logic [CNT_W-1:0] r_rank;
    logic [EXT_W-1:0] r_dim [NPOS];

    // Stage valids and enables.
    logic r_va, r_vb, r_vc, r_vd;
    logic w_en_a, w_en_b, w_en_c, w_en_d;

    // Stage A: captured word with its shape.
    t_ctrl             n_a_ctrl;
    logic              n_a_used [NPOS];
    logic [EXT_W-1:0]  n_a_ext  [NPOS];
    logic [IDX_W-1:0]  n_a_idx  [NPOS];
    logic [PAIR_W-1:0] n_a_m23;
    t_ctrl             r_a_ctrl;
    logic              r_a_used [NPOS];
    logic [EXT_W-1:0]  r_a_ext  [NPOS];
    logic [IDX_W-1:0]  r_a_idx  [NPOS];
    logic [PAIR_W-1:0] r_a_m23;

    // Stage B: per-position scale factors.
    logic [SCALE_W-1:0] n_b_scale [NPOS];
    t_ctrl              r_b_ctrl;
    logic               r_b_used  [NPOS];
    logic [EXT_W-1:0]   r_b_ext   [NPOS];
    logic [IDX_W-1:0]   r_b_idx   [NPOS];
    logic [SCALE_W-1:0] r_b_scale [NPOS];

    // Stage C: lanes.
    t_ctrl r_c_ctrl;
    t_lane w_lane [NPOS];

    logic [IDX_W-1:0] w_next [NPOS];

    assign w_en_d = ~r_vd | o_result.ready;
    assign w_en_c = ~r_vc | w_en_d;
    assign w_en_b = ~r_vb | w_en_c;
    assign w_en_a = ~r_va | w_en_b;
    assign i_item.ready = w_en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
            for (int k = 0; k < NPOS; k++) begin
                r_dim[k] <= EXT_W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANK:  r_rank   <= i_cfg_data[CNT_W-1:0];
                CFG_DIM_0: r_dim[0] <= i_cfg_data[EXT_W-1:0];
                CFG_DIM_1: r_dim[1] <= i_cfg_data[EXT_W-1:0];
                CFG_DIM_2: r_dim[2] <= i_cfg_data[EXT_W-1:0];
                CFG_DIM_3: r_dim[3] <= i_cfg_data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_en_a) r_va <= i_item.valid;
            if (w_en_b) r_vb <= r_va;
            if (w_en_c) r_vc <= r_vb;
            if (w_en_d) r_vd <= r_vc;
        end
    end

    always_comb begin
        n_a_ctrl.kind = i_item.kind;
        n_a_ctrl.err  = (i_item.index_count != r_rank) || (r_rank > RANK_LIMIT);
        n_a_idx[0] = i_item.idx_0;
        n_a_idx[1] = i_item.idx_1;
        n_a_idx[2] = i_item.idx_2;
        n_a_idx[3] = i_item.idx_3;
        // Positions beyond the rank count as extent one in the scale products.
        for (int k = 0; k < NPOS; k++) begin
            n_a_used[k] = (CNT_W'(k) < r_rank);
            n_a_ext[k]  = n_a_used[k] ? clamp_ext(r_dim[k]) : EXT_W'(1);
        end
        n_a_m23 = PAIR_W'(n_a_ext[2]) * PAIR_W'(n_a_ext[3]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_ctrl <= n_a_ctrl;
            r_a_used <= n_a_used;
            r_a_ext  <= n_a_ext;
            r_a_idx  <= n_a_idx;
            r_a_m23  <= n_a_m23;
        end
    end

    always_comb begin
        n_b_scale[3] = SCALE_W'(1);
        n_b_scale[2] = SCALE_W'(r_a_ext[3]);
        n_b_scale[1] = SCALE_W'(r_a_m23);
        n_b_scale[0] = SCALE_W'(r_a_ext[1]) * SCALE_W'(r_a_m23);
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_ctrl  <= r_a_ctrl;
            r_b_used  <= r_a_used;
            r_b_ext   <= r_a_ext;
            r_b_idx   <= r_a_idx;
            r_b_scale <= n_b_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_ctrl <= r_b_ctrl;
        end
    end

    for (genvar g = 0; g < NPOS; g++) begin : g_lane
        niao_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en_c),
            .i_used  (r_b_used[g]),
            .i_idx   (r_b_idx[g]),
            .i_ext   (r_b_ext[g]),
            .i_scale (r_b_scale[g]),
            .o_res   (w_lane[g])
        );
    end

    niao_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (w_en_d),
        .i_ctrl   (r_c_ctrl),
        .i_lane   (w_lane),
        .o_offset (o_result.linear_offset),
        .o_next   (w_next),
        .o_err    (o_result.count_error),
        .o_wrap   (o_result.wrapped)
    );

    assign o_result.valid  = r_vd;
    assign o_result.next_0 = w_next[0];
    assign o_result.next_1 = w_next[1];
    assign o_result.next_2 = w_next[2];
    assign o_result.next_3 = w_next[3];
endmodule

@@ tb/nd_index_offset_and_advance_unit_tb.sv @@
module nd_index_offset_and_advance_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import niao_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 70;

    typedef struct packed {
        logic                  kind;
        logic [CNT_W-1:0]      count;
        logic [3:0][IDX_W-1:0] idx;
    } t_word;

    typedef struct packed {
        logic [OFF_W-1:0]      offset;
        logic [3:0][IDX_W-1:0] next;
        logic                  count_error;
        logic                  wrapped;
    } t_result;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_word                 w;
        bit                    pinned;
        t_result               want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    niao_in_if  item_if ();
    niao_out_if res_if ();

    nd_index_offset_and_advance_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    // Shadow copy of the shape registers.
    logic [CNT_W-1:0] shape_rank;
    logic [EXT_W-1:0] shape_dim [4];

    t_result expected_q [$];
    bit      pin_hold;
    t_result pin_result;
    int      sink_stall_pct;

    int mismatches;
    int checked;
    int offset_words;
    int advance_words;
    int error_words;
    int wrap_words;
    int shapes_used;
    int stuck_cycles;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] extent_of(int k);
        return (shape_dim[k] > DIM_LIMIT) ? 64'(DIM_LIMIT) : 64'(shape_dim[k]);
    endfunction

    function automatic t_result address_step(t_word w);
        t_result     r;
        logic [63:0] scale;
        logic [63:0] acc;
        logic [63:0] ext;
        bit          carry;
        int          k;
        r.offset      = '0;
        r.next        = w.idx;
        r.count_error = 1'b0;
        r.wrapped     = 1'b0;
        if (w.count != shape_rank || shape_rank > RANK_LIMIT) begin
            r.count_error = 1'b1;
        end else if (w.kind == KIND_OFFSET) begin
            scale = 64'd1;
            acc   = 64'd0;
            for (k = int'(shape_rank); k > 0; k--) begin
                acc   = acc + 64'(w.idx[k-1]) * scale;
                scale = scale * extent_of(k - 1);
            end
            r.offset = acc[OFF_W-1:0];
        end else begin
            // Odometer step: the innermost position moves first, carries ripple outward.
            carry = 1'b1;
            for (k = int'(shape_rank); k > 0 && carry; k--) begin
                ext = extent_of(k - 1);
                if (64'(w.idx[k-1]) + 64'd1 < ext) begin
                    r.next[k-1] = w.idx[k-1] + 1'b1;
                    carry       = 1'b0;
                end else begin
                    r.next[k-1] = '0;
                end
            end
            r.wrapped = carry;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(logic [63:0] ext);
        int v;
        v = $urandom_range(0, 9);
        if (ext == 0 || v == 0) return IDX_W'($urandom);
        if (v == 1) return IDX_W'(ext - 1);
        if (v == 2) return '0;
        return IDX_W'($urandom_range(0, int'(ext) - 1));
    endfunction

    function automatic t_row word_row(logic kind, logic [CNT_W-1:0] cnt,
                                      logic [IDX_W-1:0] i0, logic [IDX_W-1:0] i1,
                                      logic [IDX_W-1:0] i2, logic [IDX_W-1:0] i3);
        t_row r;
        r        = '{default: '0};
        r.w.kind  = kind;
        r.w.count = cnt;
        r.w.idx   = {i3, i2, i1, i0};
        return r;
    endfunction

    function automatic t_row pin(t_row r, logic [OFF_W-1:0] off,
                                 logic [IDX_W-1:0] n0, logic [IDX_W-1:0] n1,
                                 logic [IDX_W-1:0] n2, logic [IDX_W-1:0] n3,
                                 logic err, logic wrap);
        t_row p;
        p                  = r;
        p.pinned           = 1'b1;
        p.want.offset      = off;
        p.want.next        = {n3, n2, n1, n0};
        p.want.count_error = err;
        p.want.wrapped     = wrap;
        return p;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] v);
        t_row r;
        r         = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = ri;
        r.reg_val = v;
        return r;
    endfunction

    task automatic send_word(input t_word w, input bit pinned, input t_result want);
        item_if.valid       <= 1'b1;
        item_if.kind        <= w.kind;
        item_if.index_count <= w.count;
        item_if.idx_0       <= w.idx[0];
        item_if.idx_1       <= w.idx[1];
        item_if.idx_2       <= w.idx[2];
        item_if.idx_3       <= w.idx[3];
        pin_hold            <= pinned;
        pin_result          <= want;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    // Hold off the sender until every word in flight has come back out.
    task automatic settle();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ri;
        i_cfg_data <= v;
        case (ri)
            CFG_RANK:  shape_rank   = v[CNT_W-1:0];
            CFG_DIM_0: shape_dim[0] = v;
            CFG_DIM_1: shape_dim[1] = v;
            CFG_DIM_2: shape_dim[2] = v;
            CFG_DIM_3: shape_dim[3] = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Result side: random ready stalls at the rate of the current phase.
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                res_if.ready <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_word   w;
        t_result want;
        t_result got;
        bit      took;
        bit      gave;
        bit      bad;
        took = i_rst_n && item_if.valid && item_if.ready;
        gave = i_rst_n && res_if.valid && res_if.ready;
        if (took) begin
            w.kind  = item_if.kind;
            w.count = item_if.index_count;
            w.idx   = {item_if.idx_3, item_if.idx_2, item_if.idx_1, item_if.idx_0};
            want    = pin_hold ? pin_result : address_step(w);
            expected_q.push_back(want);
            if (want.count_error) error_words++;
            else if (w.kind == KIND_OFFSET) offset_words++;
            else advance_words++;
            if (want.wrapped) wrap_words++;
        end
        if (gave) begin
            got.offset      = res_if.linear_offset;
            got.next        = {res_if.next_3, res_if.next_2, res_if.next_1, res_if.next_0};
            got.count_error = res_if.count_error;
            got.wrapped     = res_if.wrapped;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: off=%h next=%h %h %h %h err=%b wrap=%b",
                             got.offset, got.next[0], got.next[1], got.next[2],
                             got.next[3], got.count_error, got.wrapped);
            end else begin
                want = expected_q.pop_front();
                checked++;
                bad = (got.offset !== want.offset) || (got.next !== want.next) ||
                      (got.count_error !== want.count_error) ||
                      (got.wrapped !== want.wrapped);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word %0d expected: off=%h next=%h %h %h %h err=%b wrap=%b",
                                 checked, want.offset, want.next[0], want.next[1],
                                 want.next[2], want.next[3], want.count_error, want.wrapped);
                        $display("word %0d got:      off=%h next=%h %h %h %h err=%b wrap=%b",
                                 checked, got.offset, got.next[0], got.next[1],
                                 got.next[2], got.next[3], got.count_error, got.wrapped);
                    end
                end
            end
        end
        if (took || gave) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("no handshake for %0d cycles, %0d words outstanding",
                         stuck_cycles, expected_q.size());
                $display("nd_index_offset_and_advance_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_row                  tbl [$];
        t_word                 w;
        t_result               none;
        t_result               walked;
        logic [CFG_DATA_W-1:0] rv;
        logic [CNT_W-1:0]      rk;
        logic [EXT_W-1:0]      dims [4];
        logic [3:0][IDX_W-1:0] cursor;
        bit                    cursor_live;
        int                    i;
        int                    k;
        int                    ph;
        int                    n;
        int                    v;
        int                    src_pct;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        item_if.valid       = 1'b0;
        item_if.kind        = KIND_OFFSET;
        item_if.index_count = '0;
        item_if.idx_0       = '0;
        item_if.idx_1       = '0;
        item_if.idx_2       = '0;
        item_if.idx_3       = '0;
        res_if.ready        = 1'b0;
        pin_hold            = 1'b0;
        pin_result          = '0;
        sink_stall_pct      = 0;
        none                = '0;
        walked              = '0;
        mismatches          = 0;
        checked             = 0;
        offset_words        = 0;
        advance_words       = 0;
        error_words         = 0;
        wrap_words          = 0;
        shapes_used         = 1;
        stuck_cycles        = 0;
        shape_rank          = '0;
        for (k = 0; k < 4; k++) shape_dim[k] = EXT_W'(1);

        // Reset shape is a scalar: offsets are zero and every advance wraps.
        tbl.push_back(pin(word_row(KIND_OFFSET, 0, 1023, 1023, 1023, 1023),
                          0, 1023, 1023, 1023, 1023, 0, 0));
        tbl.push_back(pin(word_row(KIND_ADVANCE, 0, 1023, 0, 1023, 0),
                          0, 1023, 0, 1023, 0, 0, 1));
        tbl.push_back(pin(word_row(KIND_OFFSET, 7, 5, 6, 7, 8), 0, 5, 6, 7, 8, 1, 0));
        tbl.push_back(reg_row(CFG_RANK, 4));
        tbl.push_back(reg_row(CFG_DIM_0, 1024));
        tbl.push_back(reg_row(CFG_DIM_1, 1024));
        tbl.push_back(reg_row(CFG_DIM_2, 1024));
        tbl.push_back(reg_row(CFG_DIM_3, 1024));
        tbl.push_back(pin(word_row(KIND_OFFSET, 4, 1023, 1023, 1023, 1023),
                          40'hFF_FFFF_FFFF, 1023, 1023, 1023, 1023, 0, 0));
        tbl.push_back(pin(word_row(KIND_OFFSET, 4, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0));
        tbl.push_back(pin(word_row(KIND_ADVANCE, 4, 1023, 1023, 1023, 1023),
                          0, 0, 0, 0, 0, 0, 1));
        tbl.push_back(pin(word_row(KIND_ADVANCE, 4, 0, 0, 0, 0), 0, 0, 0, 0, 1, 0, 0));
        tbl.push_back(pin(word_row(KIND_ADVANCE, 4, 0, 0, 0, 1023), 0, 0, 0, 1, 0, 0, 0));
        tbl.push_back(pin(word_row(KIND_ADVANCE, 3, 1, 2, 3, 4), 0, 1, 2, 3, 4, 1, 0));
        tbl.push_back(pin(word_row(KIND_OFFSET, 5, 9, 8, 7, 6), 0, 9, 8, 7, 6, 1, 0));
        // Oversized outer extent, a zero extent, a unit extent and a small one.
        tbl.push_back(reg_row(CFG_DIM_0, 2047));
        tbl.push_back(reg_row(CFG_DIM_1, 0));
        tbl.push_back(reg_row(CFG_DIM_2, 1));
        tbl.push_back(reg_row(CFG_DIM_3, 2));
        tbl.push_back(word_row(KIND_OFFSET, 4, 3, 5, 7, 1));
        tbl.push_back(word_row(KIND_ADVANCE, 4, 0, 0, 0, 0));
        tbl.push_back(word_row(KIND_ADVANCE, 4, 1, 0, 0, 1));
        tbl.push_back(word_row(KIND_ADVANCE, 4, 1023, 9, 9, 1));
        tbl.push_back(reg_row(CFG_RANK, 2));
        tbl.push_back(reg_row(CFG_DIM_0, 3));
        tbl.push_back(reg_row(CFG_DIM_1, 4));
        tbl.push_back(word_row(KIND_OFFSET, 2, 2, 3, 1023, 1023));
        tbl.push_back(word_row(KIND_ADVANCE, 2, 2, 3, 1023, 0));
        tbl.push_back(word_row(KIND_ADVANCE, 2, 1, 3, 5, 5));
        // A rank above the supported limit fails even when the count agrees.
        tbl.push_back(reg_row(CFG_RANK, 7));
        tbl.push_back(pin(word_row(KIND_OFFSET, 7, 1, 2, 3, 4), 0, 1, 2, 3, 4, 1, 0));
        tbl.push_back(pin(word_row(KIND_ADVANCE, 4, 4, 3, 2, 1), 0, 4, 3, 2, 1, 1, 0));
        tbl.push_back(reg_row(CFG_RANK, 1));
        tbl.push_back(reg_row(CFG_DIM_0, 1));
        tbl.push_back(word_row(KIND_ADVANCE, 1, 0, 77, 88, 99));
        tbl.push_back(word_row(KIND_OFFSET, 1, 1023, 0, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < tbl.size(); i++) begin
            if (tbl[i].is_reg) begin
                if (i == 0 || !tbl[i-1].is_reg) begin
                    settle();
                    shapes_used++;
                end
                write_reg(tbl[i].reg_idx, tbl[i].reg_val);
                if (i + 1 == tbl.size() || !tbl[i+1].is_reg) i_cfg_we <= 1'b0;
            end else begin
                send_word(tbl[i].w, tbl[i].pinned, tbl[i].want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            v = $urandom_range(0, 19);
            if (v == 0) rk = '0;
            else if (v == 1) rk = CNT_W'($urandom_range(5, 7));
            else rk = CNT_W'($urandom_range(1, 4));
            for (k = 0; k < 4; k++) begin
                v = $urandom_range(0, 15);
                if (v == 0) dims[k] = '0;
                else if (v == 1) dims[k] = EXT_W'(1024);
                else if (v == 2) dims[k] = EXT_W'($urandom_range(1025, 2047));
                else if (v == 3) dims[k] = EXT_W'(1);
                else if (v == 4) dims[k] = EXT_W'($urandom_range(1, 1024));
                else dims[k] = EXT_W'($urandom_range(2, 6));
            end
            // Spare upper bits of the rank write are sometimes set; only the low bits count.
            rv = $urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom) : '0;
            rv[CNT_W-1:0] = rk;

            settle();
            write_reg(CFG_RANK, rv);
            write_reg(CFG_DIM_0, dims[0]);
            write_reg(CFG_DIM_1, dims[1]);
            write_reg(CFG_DIM_2, dims[2]);
            write_reg(CFG_DIM_3, dims[3]);
            i_cfg_we <= 1'b0;
            shapes_used++;

            if (ph == PHASES - 1) begin
                src_pct        = 0;
                sink_stall_pct = 0;
            end else begin
                v              = $urandom_range(0, 3);
                src_pct        = (v == 0) ? 0 : (v == 1) ? 5 : (v == 2) ? 15 : 35;
                v              = $urandom_range(0, 3);
                sink_stall_pct = (v == 0) ? 0 : (v == 1) ? 3 : (v == 2) ? 10 : 25;
            end

            cursor_live = 1'b0;
            cursor      = '0;
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (cursor_live && $urandom_range(0, 99) < 45) begin
                    // Continue walking the tensor from the last advanced position.
                    w.kind  = KIND_ADVANCE;
                    w.count = shape_rank;
                    w.idx   = cursor;
                end else begin
                    w.kind  = $urandom_range(0, 1) ? KIND_ADVANCE : KIND_OFFSET;
                    w.count = ($urandom_range(0, 99) < 88) ? shape_rank
                                                           : CNT_W'($urandom_range(0, 7));
                    for (k = 0; k < 4; k++)
                        w.idx[k] = (k < int'(shape_rank)) ? pick_index(extent_of(k))
                                                          : IDX_W'($urandom);
                end
                if (w.kind == KIND_ADVANCE && w.count == shape_rank) begin
                    walked      = address_step(w);
                    cursor      = walked.next;
                    cursor_live = 1'b1;
                end
                send_word(w, 1'b0, none);
                if (src_pct != 0 && $urandom_range(0, 149) == 0) begin
                    settle();
                end else if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
                    item_if.valid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge i_clk);
                end
            end
        end

        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d shapes: %0d offset and %0d advance words, %0d count errors.",
                 shapes_used, offset_words, advance_words, error_words);
        $display("Checked %0d result words, %0d of them wrapped; %0d mismatches.",
                 checked, wrap_words, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("nd_index_offset_and_advance_unit: match");
        end else begin
            $display("nd_index_offset_and_advance_unit: mismatch");
        end
        $finish;
    end

endmodule
